// ===== design/e2ct_pkg.sv =====
`default_nettype none

package e2ct_pkg;

	// valid and before-epoch flag that travel with each item
	typedef struct packed {
		logic valid;
		logic pre_epoch;
	} item_ctl_t;

	localparam int OFFSET_W = 17;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'h19D90; // -25200, seven hours west

	localparam int SOD_W = 17;
	localparam logic [SOD_W-1:0] SECS_PER_DAY = 17'd86400;

	// 86400 = 128 * 675; local time >> 7 is split into two 17-bit digits for the divide by 675
	localparam int SPLIT_W = 17;
	localparam logic [9:0] SOD_DIV = 10'd675;

	// reciprocal multipliers: floor(x / d) == (x * M) >> SH for x below the noted bound
	localparam int DIV675_HI_SH = 27;                                  // x < 2^17
	localparam logic [17:0] DIV675_HI_M = 18'(((64'd1 << 27) + 64'd674) / 64'd675);
	localparam int DIV675_LO_SH = 37;                                  // x < 2^27
	localparam logic [27:0] DIV675_LO_M = 28'(((64'd1 << 37) + 64'd674) / 64'd675);
	localparam int ERA_SH = 44;                                        // x < 2^26
	localparam logic [26:0] ERA_M = 27'(((64'd1 << 44) + 64'd146096) / 64'd146097);
	localparam int WK_SH = 29;                                         // x < 2^26
	localparam logic [26:0] WK_M = 27'(((64'd1 << 29) + 64'd6) / 64'd7);
	localparam int HOUR_SH = 29;                                       // x < 2^17
	localparam logic [17:0] HOUR_M = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam int D1460_SH = 29;                                      // x < 2^18
	localparam logic [18:0] D1460_M = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam int D36524_SH = 34;                                     // x < 2^18
	localparam logic [18:0] D36524_M = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam int MIN_SH = 18;                                        // x < 2^12
	localparam logic [12:0] MIN_M = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam int YOE_SH = 27;                                        // x < 2^18
	localparam logic [18:0] YOE_M = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam int C100_SH = 16;                                       // x < 2^9
	localparam logic [9:0] C100_M = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
	localparam int MP_SH = 19;                                         // x < 2^11
	localparam logic [11:0] MP_M = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

	localparam logic [19:0] DAYS_TO_MAR0 = 20'd719468;   // 0000-03-01 .. 1970-01-01
	localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
	localparam logic [17:0] LAST_DOE = 18'd146096;
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [8:0] YEARS_PER_ERA = 9'd400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0] SECS_PER_MIN = 6'd60;
	localparam logic [2:0] WD_EPOCH_BIAS = 3'd4;          // 1970-01-01 was a Thursday
	localparam logic [2:0] WD_BEFORE_EPOCH = 3'd3;        // 1969-12-31 was a Wednesday

	// first day of each month in a March-based year
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0: r = 9'd0;
			4'd1: r = 9'd31;
			4'd2: r = 9'd61;
			4'd3: r = 9'd92;
			4'd4: r = 9'd122;
			4'd5: r = 9'd153;
			4'd6: r = 9'd184;
			4'd7: r = 9'd214;
			4'd8: r = 9'd245;
			4'd9: r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// March-based month index to calendar month 1..12
	function automatic logic [3:0] month_num(input logic [3:0] mp);
		logic [3:0] r;
		case (mp)
			4'd10: r = 4'd1;
			4'd11: r = 4'd2;
			default: r = 4'(mp + 4'd3);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/e2ct_day_split.sv =====
`default_nettype none

// local seconds -> whole days and second of day, stages s2..s5
module e2ct_day_split #(
	parameter int EPOCH_BITS = 34
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire e2ct_pkg::item_ctl_t              in_ctl,
	input  wire logic signed [EPOCH_BITS+1:0]     local_secs,
	output e2ct_pkg::item_ctl_t                   out_ctl,
	output logic [EPOCH_BITS-16:0]                days,
	output logic [e2ct_pkg::SOD_W-1:0]            sod
);
	import e2ct_pkg::*;

	localparam int DW = EPOCH_BITS - 15;

	item_ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	logic [SPLIT_W-1:0] hi_s2, lo_s2;
	logic [6:0] low7_s2, low7_s3, low7_s4;
	logic [7:0] q1_s2, q1_s3, q1_s4;
	logic [SOD_W-1:0] sodneg_s2, sodneg_s3, sodneg_s4, sod_s5;
	logic [26:0] x_s3, x_s4;
	logic [16:0] q2_s4;
	logic [DW-1:0] days_s5;

	logic [SPLIT_W-1:0] hi_c;
	logic [34:0] p_hi;
	logic [9:0] r1;
	logic [54:0] p_lo;
	logic [9:0] r2;

	// sign-free upper digit of (local >> 7)
	assign hi_c = SPLIT_W'(local_secs[EPOCH_BITS:24]);
	assign p_hi = hi_c * DIV675_HI_M;
	assign r1   = 10'(hi_s2 - SPLIT_W'(q1_s2 * SOD_DIV));
	assign p_lo = x_s3 * DIV675_LO_M;
	assign r2   = 10'(x_s4 - 27'(q2_s4 * SOD_DIV));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s2 <= '{valid: in_ctl.valid, pre_epoch: local_secs[EPOCH_BITS+1]};
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s2: upper digit quotient; negative local time wraps into the prior day
		hi_s2     <= hi_c;
		lo_s2     <= local_secs[23:7];
		low7_s2   <= local_secs[6:0];
		q1_s2     <= p_hi[DIV675_HI_SH +: 8];
		sodneg_s2 <= SOD_W'(local_secs[16:0] + SECS_PER_DAY);
		// s3: remainder carried into the lower digit
		x_s3      <= {r1, lo_s2};
		q1_s3     <= q1_s2;
		low7_s3   <= low7_s2;
		sodneg_s3 <= sodneg_s2;
		// s4: lower digit quotient
		q2_s4     <= p_lo[DIV675_LO_SH +: 17];
		x_s4      <= x_s3;
		q1_s4     <= q1_s3;
		low7_s4   <= low7_s3;
		sodneg_s4 <= sodneg_s3;
		// s5
		days_s5   <= ctl_s4.pre_epoch ? '0 : DW'({q1_s4, q2_s4});
		sod_s5    <= ctl_s4.pre_epoch ? sodneg_s4 : {r2, low7_s4};
	end

	assign out_ctl = ctl_s5;
	assign days    = days_s5;
	assign sod     = sod_s5;

endmodule

`default_nettype wire

// ===== design/e2ct_civil.sv =====
`default_nettype none

// days since epoch -> March-based year, month and day of year, weekday, h:m:s; stages s6..s12
module e2ct_civil #(
	parameter int EPOCH_BITS = 34
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire e2ct_pkg::item_ctl_t              in_ctl,
	input  wire logic [EPOCH_BITS-16:0]           days,
	input  wire logic [e2ct_pkg::SOD_W-1:0]       sod,
	output e2ct_pkg::item_ctl_t                   out_ctl,
	output logic [11:0]                           year_base,
	output logic [3:0]                            mar_month,
	output logic [8:0]                            day_of_year,
	output logic [4:0]                            hour,
	output logic [5:0]                            minute,
	output logic [5:0]                            second,
	output logic [2:0]                            weekday
);
	import e2ct_pkg::*;

	localparam int DW = EPOCH_BITS - 15;
	localparam int ZW = ((DW > 20) ? DW : 20) + 1;
	localparam int EW = ZW - 17;

	item_ctl_t ctl_s6, ctl_s7, ctl_s8, ctl_s9, ctl_s10, ctl_s11, ctl_s12;

	logic [ZW-1:0] z_s6;
	logic [EW-1:0] era_s6, era_s7, era_s8, era_s9, era_s10, era_s11;
	logic [4:0] hour_s6, hour_s7, hour_s8, hour_s9, hour_s10, hour_s11, hour_s12;
	logic [SOD_W-1:0] sod_s6;
	logic [2:0] wx3_s6, wq3_s6;
	logic [2:0] wd_s7, wd_s8, wd_s9, wd_s10, wd_s11, wd_s12;
	logic [17:0] doe_s7, doe_s8, doe_s9, doe_s10;
	logic [11:0] hrem_s7, hrem_s8;
	logic [17:0] num_s8;
	logic [5:0] minute_s8, minute_s9, minute_s10, minute_s11, minute_s12;
	logic [5:0] second_s9, second_s10, second_s11, second_s12;
	logic [8:0] yoe_s9, yoe_s10, yoe_s11;
	logic [2:0] c100_s10;
	logic [8:0] doy_s11, doy_s12;
	logic [3:0] mp_s12;
	logic [11:0] yy_s12;

	logic [ZW-1:0] z_c;
	logic [ZW+26:0] p_era;
	logic [DW:0] wx_c;
	logic [DW+27:0] p_wk;
	logic [34:0] p_hour;
	logic [EW+17:0] era_days;
	logic [36:0] p_a, p_b;
	logic [24:0] p_min;
	logic [6:0] a_c;
	logic [2:0] b_c;
	logic [36:0] p_yoe;
	logic [18:0] p_c100;
	logic [17:0] ydays;
	logic [10:0] mpn;
	logic [22:0] p_mp;
	logic [EW+8:0] era_years;

	// s6 inputs
	assign z_c    = ZW'(days) + ZW'(DAYS_TO_MAR0);
	assign p_era  = z_c * ERA_M;
	assign wx_c   = (DW+1)'(days) + (DW+1)'(WD_EPOCH_BIAS);
	assign p_wk   = wx_c * WK_M;
	assign p_hour = sod * HOUR_M;
	// s7 inputs
	assign era_days = era_s6 * DAYS_PER_ERA;
	// s8 inputs
	assign p_a   = doe_s7 * D1460_M;
	assign p_b   = doe_s7 * D36524_M;
	assign p_min = hrem_s7 * MIN_M;
	assign a_c   = p_a[D1460_SH +: 7];
	assign b_c   = p_b[D36524_SH +: 3];
	// s9, s10 inputs
	assign p_yoe  = num_s8 * YOE_M;
	assign p_c100 = yoe_s9 * C100_M;
	// s11: day of the March-based year
	assign ydays = 18'(yoe_s10 * DAYS_PER_YEAR) + 18'(yoe_s10[8:2]) - 18'(c100_s10);
	// s12
	assign mpn       = 11'({doy_s11, 2'b00}) + 11'(doy_s11) + 11'd2;
	assign p_mp      = mpn * MP_M;
	assign era_years = era_s11 * YEARS_PER_ERA;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
			ctl_s12 <= '0;
		end else begin
			ctl_s6  <= in_ctl;
			ctl_s7  <= ctl_s6;
			ctl_s8  <= ctl_s7;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
			ctl_s11 <= ctl_s10;
			ctl_s12 <= ctl_s11;
		end
	end

	always_ff @(posedge clk) begin
		// s6: era, hour, weekday quotient
		z_s6       <= z_c;
		era_s6     <= p_era[ERA_SH +: EW];
		hour_s6    <= p_hour[HOUR_SH +: 5];
		sod_s6     <= sod;
		wx3_s6     <= wx_c[2:0];
		wq3_s6     <= p_wk[WK_SH +: 3];
		// s7: remainders; x - 7q mod 8 == x + q mod 8
		doe_s7     <= 18'(z_s6[17:0] - era_days[17:0]);
		era_s7     <= era_s6;
		hour_s7    <= hour_s6;
		hrem_s7    <= 12'(sod_s6[11:0] - 12'(hour_s6 * SECS_PER_HOUR));
		wd_s7      <= ctl_s6.pre_epoch ? WD_BEFORE_EPOCH : 3'(wx3_s6 + wq3_s6);
		// s8: leap-day correction within the era, minutes
		num_s8     <= doe_s7 - 18'(a_c) + 18'(b_c) - 18'(doe_s7 == LAST_DOE);
		doe_s8     <= doe_s7;
		era_s8     <= era_s7;
		hour_s8    <= hour_s7;
		hrem_s8    <= hrem_s7;
		minute_s8  <= p_min[MIN_SH +: 6];
		wd_s8      <= wd_s7;
		// s9: year of era, seconds
		yoe_s9     <= p_yoe[YOE_SH +: 9];
		doe_s9     <= doe_s8;
		era_s9     <= era_s8;
		hour_s9    <= hour_s8;
		minute_s9  <= minute_s8;
		second_s9  <= 6'(hrem_s8[5:0] - 6'(minute_s8 * SECS_PER_MIN));
		wd_s9      <= wd_s8;
		// s10: century count
		c100_s10   <= p_c100[C100_SH +: 3];
		yoe_s10    <= yoe_s9;
		doe_s10    <= doe_s9;
		era_s10    <= era_s9;
		hour_s10   <= hour_s9;
		minute_s10 <= minute_s9;
		second_s10 <= second_s9;
		wd_s10     <= wd_s9;
		// s11
		doy_s11    <= 9'(doe_s10 - ydays);
		yoe_s11    <= yoe_s10;
		era_s11    <= era_s10;
		hour_s11   <= hour_s10;
		minute_s11 <= minute_s10;
		second_s11 <= second_s10;
		wd_s11     <= wd_s10;
		// s12: March-based month, year without the Jan/Feb carry
		mp_s12     <= p_mp[MP_SH +: 4];
		doy_s12    <= doy_s11;
		yy_s12     <= 12'(era_years) + 12'(yoe_s11);
		hour_s12   <= hour_s11;
		minute_s12 <= minute_s11;
		second_s12 <= second_s11;
		wd_s12     <= wd_s11;
	end

	assign out_ctl     = ctl_s12;
	assign year_base   = yy_s12;
	assign mar_month   = mp_s12;
	assign day_of_year = doy_s12;
	assign hour        = hour_s12;
	assign minute      = minute_s12;
	assign second      = second_s12;
	assign weekday     = wd_s12;

endmodule

`default_nettype wire

// ===== design/epoch_to_civil_time.sv =====
// Epoch seconds to Gregorian civil date and time. Pulse start with an epoch count
// (seconds since 1970-01-01 00:00:00 UTC); past stages s1..s13, done is high for exactly
// one cycle with year, month, day, hour, minute, second and weekday (0 = Sunday) of
// local time = epoch_seconds + utc_offset. The receiver cannot stall the block and
// must take each result in the cycle done is high. busy never rises: the block is a
// fully pipelined chain of constant dividers (reciprocal multiplies) and takes one
// item every cycle, back to back. Local times before the epoch set
// before_epoch and return zero year/month/day; time of day and weekday stay valid.
// The UTC offset (17-bit two's complement seconds, reset -25200) is written through
// cfg_we/cfg_wdata; write it only while no item is in flight.
`default_nettype none

module epoch_to_civil_time #(
	parameter int EPOCH_BITS = 34
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// item in
	input  wire                              start,
	output logic                             busy,
	input  wire logic [EPOCH_BITS-1:0]       epoch_seconds,
	// offset register
	input  wire                              cfg_we,
	input  wire logic [e2ct_pkg::OFFSET_W-1:0] cfg_wdata,
	// result out
	output logic                             done,
	output logic [11:0]                      year,
	output logic [3:0]                       month,
	output logic [4:0]                       day,
	output logic [4:0]                       hour,
	output logic [5:0]                       minute,
	output logic [5:0]                       second,
	output logic [2:0]                       weekday,
	output logic                             before_epoch
);
	import e2ct_pkg::*;

	localparam int LW = EPOCH_BITS + 2;   // signed local time
	localparam int DW = EPOCH_BITS - 15;  // whole days
	localparam int LATENCY = 13;

	logic [OFFSET_W-1:0] utc_offset_q;

	// s1: local time
	item_ctl_t ctl_s1;
	logic signed [LW-1:0] local_s1;

	item_ctl_t split_ctl;
	logic [DW-1:0] split_days;
	logic [SOD_W-1:0] split_sod;

	item_ctl_t civ_ctl;
	logic [11:0] civ_year_base;
	logic [3:0] civ_mp;
	logic [8:0] civ_doy;
	logic [4:0] civ_hour;
	logic [5:0] civ_minute, civ_second;
	logic [2:0] civ_wd;

	// s13: output register
	item_ctl_t ctl_s13;
	logic [11:0] year_s13;
	logic [3:0] month_s13;
	logic [4:0] day_s13;
	logic [4:0] hour_s13;
	logic [5:0] minute_s13, second_s13;
	logic [2:0] wd_s13;

	logic [3:0] month_c;
	logic accept;

	// pipeline never backs up
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utc_offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			utc_offset_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s13 <= '0;
		end else begin
			ctl_s1  <= '{valid: accept, pre_epoch: 1'b0};
			ctl_s13 <= civ_ctl;
		end
	end

	always_ff @(posedge clk) begin
		local_s1 <= $signed({2'b00, epoch_seconds}) + LW'($signed(utc_offset_q));
	end

	// s2..s5: floor split into days and second of day
	e2ct_day_split #(
		.EPOCH_BITS (EPOCH_BITS)
	) u_day_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ctl     (ctl_s1),
		.local_secs (local_s1),
		.out_ctl    (split_ctl),
		.days       (split_days),
		.sod        (split_sod)
	);

	// s6..s12: civil-from-days on a March-based year, plus time of day
	e2ct_civil #(
		.EPOCH_BITS (EPOCH_BITS)
	) u_civil (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ctl      (split_ctl),
		.days        (split_days),
		.sod         (split_sod),
		.out_ctl     (civ_ctl),
		.year_base   (civ_year_base),
		.mar_month   (civ_mp),
		.day_of_year (civ_doy),
		.hour        (civ_hour),
		.minute      (civ_minute),
		.second      (civ_second),
		.weekday     (civ_wd)
	);

	assign month_c = month_num(civ_mp);

	// s13: January and February belong to the next calendar year; date zeroed before epoch
	always_ff @(posedge clk) begin
		year_s13   <= civ_ctl.pre_epoch ? '0 : 12'(civ_year_base + 12'(month_c <= 4'd2));
		month_s13  <= civ_ctl.pre_epoch ? '0 : month_c;
		day_s13    <= civ_ctl.pre_epoch ? '0 : 5'(civ_doy - month_start(civ_mp) + 9'd1);
		hour_s13   <= civ_hour;
		minute_s13 <= civ_minute;
		second_s13 <= civ_second;
		wd_s13     <= civ_wd;
	end

	assign done         = ctl_s13.valid;
	assign before_epoch = ctl_s13.pre_epoch;
	assign year         = year_s13;
	assign month        = month_s13;
	assign day          = day_s13;
	assign hour         = hour_s13;
	assign minute       = minute_s13;
	assign second       = second_s13;
	assign weekday      = wd_s13;

	// every accepted item comes out after the fixed latency
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result missing after fixed latency");

	// no result without an item accepted at the matching cycle
	a_no_phantom : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without an accepted item");

	// before the epoch: zero date and the weekday of 1969-12-31
	a_before : assert property (@(posedge clk) disable iff (!arst_n)
		(done && before_epoch) |->
			(year == 12'd0 && month == 4'd0 && day == 5'd0 && weekday == WD_BEFORE_EPOCH))
		else $error("before-epoch result malformed");

	// calendar and clock fields stay in range
	a_ranges : assert property (@(posedge clk) disable iff (!arst_n)
		(done && !before_epoch) |->
			(month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31 &&
			 hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6))
		else $error("result field out of range");

endmodule

`default_nettype wire

// ===== tb/epoch_to_civil_time_test.sv =====
`default_nettype none

module epoch_to_civil_time_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int EPOCH_W = 34;
	// pipeline depth of the block; used for the settle wait at the end
	localparam int PIPE_LATENCY = 13;
	localparam int MAX_PRINTED = 40;
	// offset after reset: seven hours west
	localparam logic [e2ct_pkg::OFFSET_W-1:0] RESET_OFFSET = 17'(-25200);

	// one converted timestamp, as seen on the result ports
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
		logic        before_epoch;
	} civil_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [EPOCH_W-1:0]            epoch_seconds = '0;
	logic                          cfg_we = 1'b0;
	logic [e2ct_pkg::OFFSET_W-1:0] cfg_wdata = '0;
	logic                          done;
	logic [11:0]                   year;
	logic [3:0]                    month;
	logic [4:0]                    day;
	logic [4:0]                    hour;
	logic [5:0]                    minute;
	logic [5:0]                    second;
	logic [2:0]                    weekday;
	logic                          before_epoch;

	// TB copy of the zone offset register, raw 17-bit two's complement
	logic [e2ct_pkg::OFFSET_W-1:0] zone_offset;

	// converted dates still owed by the block, oldest first
	civil_t pending_dates[$];

	int unsigned stamps_sent;
	int unsigned stamps_checked;
	int unsigned pre_epoch_stamps;
	int unsigned offset_writes;
	int unsigned errors;
	int unsigned sender_idle_pct;

	epoch_to_civil_time #(.EPOCH_BITS(EPOCH_W)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.epoch_seconds(epoch_seconds),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.year         (year),
		.month        (month),
		.day          (day),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.weekday      (weekday),
		.before_epoch (before_epoch)
	);

	always #10 clk = ~clk;

	// Civil date of epoch + offset. Floor split into days and seconds of day, so the
	// time of day and weekday stay right before the epoch; date fields only from
	// the epoch on, via the March-based era / year-of-era day split.
	function automatic civil_t expected_civil(input logic [EPOCH_W-1:0] epoch,
			input logic [e2ct_pkg::OFFSET_W-1:0] ofs_raw);
		civil_t c;
		longint local_s, sod, days;
		longint z, era, doe, yoe, doy, mp, yy;
		c = '0;
		local_s = longint'({30'b0, epoch}) + longint'(signed'(ofs_raw));
		sod = local_s % 86400;
		if (sod < 0) begin
			sod += 86400;
		end
		days = (local_s - sod) / 86400;
		c.hour = 5'(sod / 3600);
		c.minute = 6'((sod % 3600) / 60);
		c.second = 6'(sod % 60);
		c.weekday = 3'((days % 7 + 11) % 7);   // day 0 was a Thursday
		c.before_epoch = (local_s < 0);
		if (!c.before_epoch) begin
			z = days + 719468;                  // count from 0000-03-01
			era = z / 146097;
			doe = z - era * 146097;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp = (5 * doy + 2) / 153;           // 0 is March
			yy = yoe + era * 400;
			c.day = 5'(doy - (153 * mp + 2) / 5 + 1);
			c.month = (mp < 10) ? 4'(mp + 3) : 4'(mp - 9);
			if (c.month <= 4'd2) begin
				yy += 1;                        // Jan/Feb belong to the next civil year
			end
			c.year = 12'(yy);
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (errors < MAX_PRINTED) begin
			$display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
		end
		errors++;
	endtask

	// Result checker: done is a one-cycle strobe, sampled here at the edge ending it.
	always @(posedge clk) begin
		civil_t got, want;
		if (arst_n && done) begin
			got = '{year, month, day, hour, minute, second, weekday, before_epoch};
			if (pending_dates.size() == 0) begin
				report_mismatch("unexpected result, year", got.year, 0);
			end else begin
				want = pending_dates.pop_front();
				stamps_checked++;
				if (got.year != want.year) report_mismatch("year", got.year, want.year);
				if (got.month != want.month) report_mismatch("month", got.month, want.month);
				if (got.day != want.day) report_mismatch("day", got.day, want.day);
				if (got.hour != want.hour) report_mismatch("hour", got.hour, want.hour);
				if (got.minute != want.minute)
					report_mismatch("minute", got.minute, want.minute);
				if (got.second != want.second)
					report_mismatch("second", got.second, want.second);
				if (got.weekday != want.weekday)
					report_mismatch("weekday", got.weekday, want.weekday);
				if (got.before_epoch != want.before_epoch)
					report_mismatch("before_epoch", got.before_epoch, want.before_epoch);
			end
		end
	end

	// Send one timestamp. Optional idle gap first (start is sampled low by the clock, so it
	// never drops and rises in the same step), then hold start until taken.
	task automatic send_epoch(input logic [EPOCH_W-1:0] value);
		civil_t want;
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		start <= 1'b1;
		epoch_seconds <= value;
		do @(posedge clk); while (busy);
		want = expected_civil(value, zone_offset);
		pending_dates.push_back(want);
		stamps_sent++;
		if (want.before_epoch) pre_epoch_stamps++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
	endtask

	// offset may only change with nothing in flight; every item yields a result,
	// so an empty queue means the pipe is empty
	task automatic set_zone_offset(input logic [e2ct_pkg::OFFSET_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		zone_offset = value;
		offset_writes++;
	endtask

	function automatic logic [EPOCH_W-1:0] random_epoch();
		longint v;
		case ($urandom_range(3))
			0: v = $urandom_range(120000);   // near the epoch, crosses it under any negative offset
			1: v = longint'($urandom_range(198841)) * 86400 + $urandom_range(7200) - 3600;
			default: v = (longint'($urandom_range(3)) << 32) | longint'($urandom);
		endcase
		if (v < 0) v = 0;
		return v[EPOCH_W-1:0];
	endfunction

	function automatic logic [e2ct_pkg::OFFSET_W-1:0] random_offset();
		int ofs;
		if ($urandom_range(3) == 0) begin
			return e2ct_pkg::OFFSET_W'($urandom);   // any raw pattern, past +-14 h too
		end
		ofs = int'($urandom_range(100800)) - 50400;
		return e2ct_pkg::OFFSET_W'(ofs);
	endfunction

	// Reset value of the offset (seven hours west): epoch 0 lands the evening before.
	task automatic test_reset_offset();
		send_epoch(34'd0);
		send_epoch(34'd25199);              // last second before local epoch
		send_epoch(34'd25200);              // local midnight 1970-01-01
		send_epoch(34'd111599);             // end of the first local day
	endtask

	// UTC calendar corners: leap rules, century years, widest epoch values.
	task automatic test_calendar_edges();
		set_zone_offset('0);
		send_epoch(34'd0);
		send_epoch(34'd68169600);           // 1972-02-29
		send_epoch(34'd946684799);          // last second of 1999
		send_epoch(34'd951782400);          // 2000-02-29, 400-year leap
		send_epoch(34'd2147483647);         // signed 32-bit rollover
		send_epoch(34'd4107542399);         // 2100-02-28 23:59:59, century not leap
		send_epoch(34'd4107542400);         // 2100-03-01
		send_epoch(34'd4294967296);         // past unsigned 32-bit
		send_epoch(34'd13574563200);        // 2400-02-29
		send_epoch(34'h3_FFFF_FFFF);        // largest count, latest year
	endtask

	// Offset limits, plus raw values past the nominal range.
	task automatic test_offset_extremes();
		set_zone_offset(17'(-50400));
		send_epoch(34'd0);
		send_epoch(34'd50400);
		set_zone_offset(17'd50400);
		send_epoch(34'h3_FFFF_FFFF);
		set_zone_offset(17'h1_0000);        // most negative raw value
		send_epoch(34'd65535);
		set_zone_offset(17'h0_FFFF);        // most positive raw value
		send_epoch(34'd0);
		set_zone_offset(17'h1_FFFF);        // minus one second
		send_epoch(34'd0);
	endtask

	// Random timestamps in blocks of 100, each under its own offset. The block's
	// receiver side cannot be stalled, so only the sender idles: none, heavy, light.
	task automatic test_random();
		int unsigned idle_plan[3] = '{0, 79, 11};
		logic [e2ct_pkg::OFFSET_W-1:0] fixed_offsets[4] =
			'{17'(-50400), 17'd50400, 17'd0, RESET_OFFSET};
		for (int blk = 0; blk < 10; blk++) begin
			set_zone_offset(blk < 4 ? fixed_offsets[blk] : random_offset());
			sender_idle_pct = idle_plan[blk % 3];
			repeat (100) send_epoch(random_epoch());
		end
		sender_idle_pct = 0;
	endtask

	initial begin
		zone_offset = RESET_OFFSET;
		sender_idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_offset();
		test_calendar_edges();
		test_offset_extremes();
		test_random();

		wait_drained();
		// let any stray strobe show up before the verdict
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		$display("converted %0d timestamps (%0d before the local epoch) under %0d offsets,",
			stamps_checked, pre_epoch_stamps, offset_writes + 1);
		$display("with leap and century days, widest counts and idle/back-to-back starts");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// generous cap: a correct run needs well under a tenth of this
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
